[rtl/core/osm_pkg.sv]
// ---------------------------------------------------------------------------
// osm_pkg: shared types and constants of the order-statistic multiset
// Command codes, the transaction payloads and the sequencer states.
// ---------------------------------------------------------------------------
package osm_pkg;

   typedef enum logic [3:0] {
      CMD_INSERT        = 4'd0,
      CMD_INSERT_UNIQUE = 4'd1,
      CMD_ERASE_ONE     = 4'd2,
      CMD_ERASE_ALL     = 4'd3,
      CMD_COUNT         = 4'd4,
      CMD_KTH           = 4'd5,
      CMD_RANK_LT       = 4'd6,
      CMD_RANK_LE       = 4'd7,
      CMD_SUM_LT        = 4'd8,
      CMD_SUM_LE        = 4'd9,
      CMD_RANGE_SUM     = 4'd10,
      CMD_CLEAR         = 4'd11
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT,
      ST_DRAIN,
      ST_PUT,
      ST_DONE
   } state_type;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic signed [31:0] KEY_NONE = -32'sd1;

   typedef struct packed {
      logic [3:0]         command;
      logic signed [31:0] key;
      logic signed [31:0] upper_key;
      logic [30:0]        rank;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_key;
      logic               found;
      logic [31:0]        result_count;
      logic signed [63:0] result_sum;
      logic [31:0]        total_size;
      logic               is_empty;
      logic               status;
   } rsp_type;

   // Results of one pass over the table, apart from the table position.
   typedef struct packed {
      logic               present;
      logic [31:0]        pos_count;
      logic signed [63:0] sum_acc;
      logic               kth_found;
      logic signed [31:0] kth_key;
   } scan_res_type;

endpackage

[rtl/core/osm_if.sv]
// ---------------------------------------------------------------------------
// osm_if: valid/ready channels of the order-statistic multiset
// One interface for the command channel and one for the result channel.
// ---------------------------------------------------------------------------
interface osm_req_if;
   import osm_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface osm_rsp_if;
   import osm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/core/osm_ram.sv]
// ---------------------------------------------------------------------------
// osm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module osm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
      read_data <= mem[read_addr];
   end

endmodule

[rtl/core/osm_scan.sv]
// ---------------------------------------------------------------------------
// osm_scan: table walk datapath
// Compares each entry with the operand, multiplies key by count and keeps
// the position, count and saturating sum accumulators, one entry a cycle.
// ---------------------------------------------------------------------------
module osm_scan #(
   parameter int CAPACITY = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          issue,
   input  logic [$clog2(CAPACITY+1)-1:0] issue_index,
   input  logic [$clog2(CAPACITY+1)-1:0] used,
   input  logic [3:0]                    command,
   input  logic signed [31:0]            key,
   input  logic signed [31:0]            upper_key,
   input  logic [30:0]                   rank,
   input  logic signed [31:0]            entry_key,
   input  logic [31:0]                   entry_count,
   output logic                          busy,
   output logic [$clog2(CAPACITY+1)-1:0] pos,
   output logic [32+$clog2(CAPACITY+1)-1:0] count_acc,
   output osm_pkg::scan_res_type         res
);
   import osm_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int TW = 32 + CW;

   logic                 rv_ff, pv_ff;
   logic [CW-1:0]        idx_ff;
   logic                 pos_found_ff;
   logic [CW-1:0]        pos_ff;
   logic                 present_ff;
   logic [31:0]          pcnt_ff;
   logic signed [63:0]   prod_ff;
   logic                 sum_sel_ff, cnt_sel_ff;
   logic [31:0]          cnt2_ff;
   logic signed [31:0]   key2_ff;
   logic [TW-1:0]        cnt_acc_ff;
   logic signed [63:0]   sum_acc_ff;
   logic                 kfound_ff;
   logic signed [31:0]   kkey_ff;

   logic                 lt, le, eq, in_range;
   logic                 sum_sel, cnt_sel;
   logic signed [65:0]   product;
   logic [TW-1:0]        cnt_acc_in;
   logic signed [64:0]   sum_wide;
   logic signed [63:0]   sum_acc_in;

   assign lt       = entry_key < key;
   assign eq       = entry_key == key;
   assign le       = lt | eq;
   assign in_range = (entry_key >= key) && (entry_key <= upper_key);
   assign product  = entry_key * $signed({1'b0, entry_count});

   always_comb begin
      sum_sel = 1'b0;
      cnt_sel = 1'b0;
      case (command)
         CMD_KTH:       cnt_sel = 1'b1;
         CMD_RANK_LT:   cnt_sel = lt;
         CMD_RANK_LE:   cnt_sel = le;
         CMD_SUM_LT:    sum_sel = lt;
         CMD_SUM_LE:    sum_sel = le;
         CMD_RANGE_SUM: sum_sel = in_range;
         default:       ;
      endcase
   end

   // Second stage: accumulate and saturate the key sum at the 64-bit ends.
   assign cnt_acc_in = cnt_acc_ff + (cnt_sel_ff ? {{CW{1'b0}}, cnt2_ff} : '0);
   assign sum_wide   = {sum_acc_ff[63], sum_acc_ff}
                     + (sum_sel_ff ? {prod_ff[63], prod_ff} : 65'sd0);
   always_comb begin
      if (sum_wide[64] != sum_wide[63]) begin
         sum_acc_in = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sum_acc_in = sum_wide[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else if (start) begin
         rv_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else begin
         rv_ff <= issue;
         pv_ff <= rv_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= issue_index;
      prod_ff    <= product[63:0];
      sum_sel_ff <= sum_sel;
      cnt_sel_ff <= cnt_sel;
      cnt2_ff    <= entry_count;
      key2_ff    <= entry_key;
      if (start) begin
         pos_found_ff <= 1'b0;
         pos_ff       <= used;
         present_ff   <= 1'b0;
         pcnt_ff      <= '0;
         cnt_acc_ff   <= '0;
         sum_acc_ff   <= '0;
         kfound_ff    <= 1'b0;
         kkey_ff      <= KEY_NONE;
      end else begin
         if (rv_ff && !pos_found_ff && !lt) begin
            pos_found_ff <= 1'b1;
            pos_ff       <= idx_ff;
            present_ff   <= eq;
            pcnt_ff      <= entry_count;
         end
         if (pv_ff) begin
            cnt_acc_ff <= cnt_acc_in;
            sum_acc_ff <= sum_acc_in;
            if (!kfound_ff && ({{(TW-31){1'b0}}, rank} < cnt_acc_in)) begin
               kfound_ff <= 1'b1;
               kkey_ff   <= key2_ff;
            end
         end
      end
   end

   assign busy          = rv_ff | pv_ff;
   assign pos           = pos_ff;
   assign count_acc     = cnt_acc_ff;
   assign res.present   = present_ff;
   assign res.pos_count = pcnt_ff;
   assign res.sum_acc   = sum_acc_ff;
   assign res.kth_found = kfound_ff;
   assign res.kth_key   = kkey_ff;

endmodule

[rtl/core/order_statistic_multiset.sv]
// ---------------------------------------------------------------------------
// order_statistic_multiset: sorted multiset of signed keys with counts
// Sorted table in RAM, one walk per command, shifts for insert and erase.
// ---------------------------------------------------------------------------
// The block holds a multiset of signed 32-bit keys as a table of distinct
// keys in ascending order, each with a 32-bit saturating repeat count, in
// two single-port-read RAMs of CAPACITY entries. Each command transaction
// yields exactly one result transaction. The sequencer walks the table once,
// one entry per cycle through the RAM read port, the compare unit and the
// key-times-count multiplier. An insert of a new key or an erase of a key's
// last copy then moves the entries above the position by one slot, one entry
// per cycle through the RAM write port. The command channel is not ready
// while a command is in progress; a finished result sits in an output
// register, so the next command can begin while the result waits to be
// taken. The total size is kept exactly and saturates only on its way out.
// No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module order_statistic_multiset #(
   parameter int CAPACITY = 1024
) (
   input  logic     clock,
   input  logic     reset,
   osm_req_if.sink  req_chan,
   osm_rsp_if.source rsp_chan
);
   import osm_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int TW = 32 + CW;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_COUNT = CW'(1);

   state_type state_ff, state_in;

   // Latched command transaction.
   logic [3:0]         cmd_ff;
   logic signed [31:0] key_ff, upper_ff;
   logic [30:0]        rank_ff;

   // Table bookkeeping: distinct keys held and exact total of all counts.
   logic [CW-1:0] used_ff;
   logic [TW-1:0] total_ff;

   // Walk and shift pointers.
   logic [CW-1:0] ptr_ff;
   logic [CW-1:0] shift_last_ff;
   logic          shift_up_ff;
   logic          pend_ff;
   logic [AW-1:0] pend_addr_ff;

   // Final single-entry write.
   logic [AW-1:0]      put_addr_ff;
   logic signed [31:0] put_key_ff;
   logic [31:0]        put_cnt_ff;

   // Working result and output register.
   rsp_type res_ff;
   rsp_type out_ff;
   logic    out_valid_ff;

   logic               accept, start, issue, scan_busy;
   logic [CW-1:0]      scan_pos;
   logic [TW-1:0]      scan_count;
   scan_res_type       scan_res;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic signed [31:0] ram_wkey, ram_rkey;
   logic [31:0]        ram_wcnt, ram_rcnt;
   logic               out_load;
   logic               rsp_take;
   rsp_type            res_in;
   rsp_type            res_final;
   logic [31:0]        put_cnt_in;
   logic [31:0]        total_sat;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;
   assign start    = accept;

   // -------------------------------------------------------------------------
   // Next state.
   // -------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!issue && !scan_busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
            if (cmd_ff == CMD_INSERT || cmd_ff == CMD_INSERT_UNIQUE) begin
               if (scan_res.present) begin
                  if (cmd_ff == CMD_INSERT && scan_res.pos_count != COUNT_MAX) begin
                     state_in = ST_PUT;
                  end
               end else if (used_ff != CAP_COUNT) begin
                  state_in = (scan_pos == used_ff) ? ST_PUT : ST_SHIFT;
               end
            end else if (cmd_ff == CMD_ERASE_ONE || cmd_ff == CMD_ERASE_ALL) begin
               if (scan_res.present) begin
                  if (cmd_ff == CMD_ERASE_ONE && scan_res.pos_count > 32'd1) begin
                     state_in = ST_PUT;
                  end else if (scan_pos != used_ff - ONE_COUNT) begin
                     state_in = ST_SHIFT;
                  end
               end
            end
         end
         ST_SHIFT: begin
            if (ptr_ff == shift_last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = shift_up_ff ? ST_PUT : ST_DONE;
         end
         ST_PUT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // -------------------------------------------------------------------------
   // Outputs of the sequencer.
   // -------------------------------------------------------------------------
   always_comb begin
      issue     = 1'b0;
      out_load  = 1'b0;
      ram_raddr = ptr_ff[AW-1:0];
      unique case (state_ff)
         ST_SCAN:  issue    = ptr_ff < used_ff;
         ST_DONE:  out_load = !out_valid_ff || rsp_chan.ready;
         default:  ;
      endcase
   end

   // A pending shift write carries the entry read in the cycle before.
   always_comb begin
      ram_we    = pend_ff || (state_ff == ST_PUT);
      ram_waddr = pend_ff ? pend_addr_ff : put_addr_ff;
      ram_wkey  = pend_ff ? ram_rkey : put_key_ff;
      ram_wcnt  = pend_ff ? ram_rcnt : put_cnt_ff;
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;

   // -------------------------------------------------------------------------
   // Result of the walk and the count to be written back at the position.
   // -------------------------------------------------------------------------
   always_comb begin
      res_in     = '0;
      put_cnt_in = scan_res.pos_count;
      if (cmd_ff <= CMD_COUNT) begin
         res_in.found = scan_res.present;
      end
      unique case (cmd_ff)
         CMD_INSERT, CMD_INSERT_UNIQUE: begin
            if (scan_res.present) begin
               if (cmd_ff == CMD_INSERT && scan_res.pos_count != COUNT_MAX) begin
                  res_in.result_count = scan_res.pos_count + 32'd1;
                  put_cnt_in          = scan_res.pos_count + 32'd1;
               end else begin
                  res_in.result_count = scan_res.pos_count;
               end
            end else if (used_ff == CAP_COUNT) begin
               res_in.status = 1'b1;
            end else begin
               res_in.result_count = 32'd1;
               put_cnt_in          = 32'd1;
            end
         end
         CMD_ERASE_ONE, CMD_ERASE_ALL: begin
            if (scan_res.present && cmd_ff == CMD_ERASE_ONE &&
                scan_res.pos_count > 32'd1) begin
               res_in.result_count = scan_res.pos_count - 32'd1;
               put_cnt_in          = scan_res.pos_count - 32'd1;
            end
         end
         CMD_COUNT: begin
            if (scan_res.present) begin
               res_in.result_count = scan_res.pos_count;
            end
         end
         CMD_KTH: begin
            res_in.result_key = scan_res.kth_key;
            res_in.found      = scan_res.kth_found;
         end
         CMD_RANK_LT, CMD_RANK_LE: begin
            res_in.result_count = (|scan_count[TW-1:32]) ? COUNT_MAX : scan_count[31:0];
         end
         CMD_SUM_LT, CMD_SUM_LE, CMD_RANGE_SUM: begin
            res_in.result_sum = scan_res.sum_acc;
         end
         default: ;
      endcase
   end

   // The size fields come from the settled total when the result is loaded.
   assign total_sat = (|total_ff[TW-1:32]) ? COUNT_MAX : total_ff[31:0];

   always_comb begin
      res_final            = res_ff;
      res_final.total_size = total_sat;
      res_final.is_empty   = (total_ff == '0);
   end

   // -------------------------------------------------------------------------
   // Control registers.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         total_ff     <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= (state_ff == ST_SHIFT);
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
         if (state_ff == ST_DECIDE) begin
            unique case (cmd_ff)
               CMD_INSERT, CMD_INSERT_UNIQUE: begin
                  if (scan_res.present) begin
                     if (cmd_ff == CMD_INSERT && scan_res.pos_count != COUNT_MAX) begin
                        total_ff <= total_ff + TW'(1);
                     end
                  end else if (used_ff != CAP_COUNT) begin
                     used_ff  <= used_ff + ONE_COUNT;
                     total_ff <= total_ff + TW'(1);
                  end
               end
               CMD_ERASE_ONE, CMD_ERASE_ALL: begin
                  if (scan_res.present) begin
                     if (cmd_ff == CMD_ERASE_ONE && scan_res.pos_count > 32'd1) begin
                        total_ff <= total_ff - TW'(1);
                     end else begin
                        used_ff  <= used_ff - ONE_COUNT;
                        total_ff <= total_ff - {{CW{1'b0}}, scan_res.pos_count};
                     end
                  end
               end
               CMD_CLEAR: begin
                  used_ff  <= '0;
                  total_ff <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   // -------------------------------------------------------------------------
   // Datapath registers.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_chan.data.command;
         key_ff   <= req_chan.data.key;
         upper_ff <= req_chan.data.upper_key;
         rank_ff  <= req_chan.data.rank;
         ptr_ff   <= '0;
      end else if (issue) begin
         ptr_ff <= ptr_ff + ONE_COUNT;
      end else if (state_ff == ST_SHIFT) begin
         ptr_ff <= shift_up_ff ? ptr_ff - ONE_COUNT : ptr_ff + ONE_COUNT;
      end
      if (state_ff == ST_SHIFT) begin
         pend_addr_ff <= shift_up_ff ? AW'(ptr_ff + ONE_COUNT) : AW'(ptr_ff - ONE_COUNT);
      end
      if (out_load) begin
         out_ff <= res_final;
      end

      // Inserts move the upper entries up from the top, erases move them
      // down from just above the position.
      if (state_ff == ST_DECIDE) begin
         res_ff      <= res_in;
         put_addr_ff <= AW'(scan_pos);
         put_key_ff  <= key_ff;
         put_cnt_ff  <= put_cnt_in;
         if (cmd_ff == CMD_INSERT || cmd_ff == CMD_INSERT_UNIQUE) begin
            shift_up_ff   <= 1'b1;
            ptr_ff        <= used_ff - ONE_COUNT;
            shift_last_ff <= scan_pos;
         end else begin
            shift_up_ff   <= 1'b0;
            ptr_ff        <= scan_pos + ONE_COUNT;
            shift_last_ff <= used_ff - ONE_COUNT;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Table storage and the walk datapath.
   // -------------------------------------------------------------------------
   osm_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ram_waddr),
      .write_data (ram_wkey),
      .read_addr  (ram_raddr),
      .read_data  (ram_rkey)
   );

   osm_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_count_ram (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ram_waddr),
      .write_data (ram_wcnt),
      .read_addr  (ram_raddr),
      .read_data  (ram_rcnt)
   );

   osm_scan #(
      .CAPACITY (CAPACITY)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .issue       (issue),
      .issue_index (ptr_ff),
      .used        (used_ff),
      .command     (cmd_ff),
      .key         (key_ff),
      .upper_key   (upper_ff),
      .rank        (rank_ff),
      .entry_key   (ram_rkey),
      .entry_count (ram_rcnt),
      .busy        (scan_busy),
      .pos         (scan_pos),
      .count_acc   (scan_count),
      .res         (scan_res)
   );

   // -------------------------------------------------------------------------
   // Assertions.
   // -------------------------------------------------------------------------
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CAP_COUNT)
      else $error("distinct key count exceeds capacity");

   a_pend_after_shift: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff == ST_SHIFT))
      else $error("shift write without a shift read");

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SCAN)
      else $error("accepted transaction did not start a walk");

   a_no_put_overlap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUT |-> !pend_ff)
      else $error("entry write collides with a shift write");

endmodule
